// ----- sv/ccs_pkg.sv -----
package ccs_pkg;

   // Field and datapath widths
   localparam int CORNER_BITS = 16;
   localparam int COORD_BITS = 17;
   localparam int H_BITS = 19;
   localparam int LEVEL_IDX_BITS = 3;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int DEFAULT_MAX_LEVELS = 6;
   localparam int PROD_BITS = H_BITS + COORD_BITS;
   localparam int NUM_BITS = PROD_BITS + 1;
   localparam int DEN_BITS = H_BITS + 1;
   localparam int REM_BITS = DEN_BITS + 1;
   localparam int QUO_BITS = 18;
   localparam int DIV_BITS_PER_CYCLE = 3;
   localparam int DIV_CYCLES = QUO_BITS / DIV_BITS_PER_CYCLE;
   localparam int DIV_STEP_BITS = $clog2(DIV_CYCLES);
   localparam int LANES = 4;
   localparam int FIFO_DEPTH = 4;

   // Register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_COUNT = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LEVEL_BASE = 3'd1;

   // Sequencer states of the front and the back
   typedef enum logic {FR_IDLE, FR_SCAN} front_state_type;

   typedef enum logic [2:0] {BK_IDLE, BK_MUL, BK_PREP, BK_DIV, BK_DONE} back_state_type;

   // Segment shape of one triangle
   typedef enum logic [3:0] {
      TC_NONE,
      TC_AB,
      TC_BC,
      TC_CA,
      TC_A_XBC,
      TC_B_XCA,
      TC_C_XAB,
      TC_XAB_XBC,
      TC_XBC_XCA,
      TC_XCA_XAB
   } tri_case_type;

   typedef enum logic [1:0] {
      VX_A,
      VX_B,
      VX_C
   } vertex_type;

   typedef struct packed {
      logic       is_cross;
      vertex_type p;
      vertex_type q;
   } point_type;

   typedef struct packed {
      point_type first;
      point_type second;
   } seg_plan_type;

   // One coordinate of an end point: (hq*cp - hp*cq) / (hq - hp)
   typedef struct packed {
      logic signed [H_BITS-1:0]     hp;
      logic signed [H_BITS-1:0]     hq;
      logic signed [COORD_BITS-1:0] cp;
      logic signed [COORD_BITS-1:0] cq;
   } lane_type;

   typedef struct packed {
      logic                      has_segment;
      logic                      last;
      logic [LEVEL_IDX_BITS-1:0] level_index;
      lane_type [LANES-1:0]      lane;
   } job_type;

   // Sign codes: negative, zero, positive
   localparam logic [1:0] SGN_NEG = 2'd0;
   localparam logic [1:0] SGN_ZERO = 2'd1;
   localparam logic [1:0] SGN_POS = 2'd2;

   localparam tri_case_type TRI_CASE_TABLE [27] = '{
      TC_NONE, TC_NONE, TC_XBC_XCA,
      TC_NONE, TC_BC, TC_B_XCA,
      TC_XAB_XBC, TC_C_XAB, TC_XCA_XAB,
      TC_NONE, TC_CA, TC_A_XBC,
      TC_AB, TC_CA, TC_AB,
      TC_A_XBC, TC_CA, TC_NONE,
      TC_XCA_XAB, TC_C_XAB, TC_XAB_XBC,
      TC_B_XCA, TC_BC, TC_NONE,
      TC_XBC_XCA, TC_NONE, TC_NONE
   };

   function automatic logic [1:0] sign_code(logic signed [H_BITS-1:0] h);
      logic [1:0] s;
      if (h == '0) s = SGN_ZERO;
      else if (h < 0) s = SGN_NEG;
      else s = SGN_POS;
      return s;
   endfunction

   function automatic tri_case_type tri_case_lookup(logic [1:0] sa, logic [1:0] sb,
                                                    logic [1:0] sc);
      logic [4:0] idx;
      tri_case_type tc;
      idx = 5'(sa) * 5'd9 + 5'(sb) * 5'd3 + 5'(sc);
      if (idx < 5'd27) tc = TRI_CASE_TABLE[idx];
      else tc = TC_NONE;
      return tc;
   endfunction

   function automatic point_type vtx(vertex_type p);
      return '{is_cross: 1'b0, p: p, q: p};
   endfunction

   function automatic point_type xing(vertex_type p, vertex_type q);
      return '{is_cross: 1'b1, p: p, q: q};
   endfunction

   function automatic seg_plan_type case_points(tri_case_type tc);
      seg_plan_type sp;
      unique case (tc)
         TC_AB:      sp = '{vtx(VX_A), vtx(VX_B)};
         TC_BC:      sp = '{vtx(VX_B), vtx(VX_C)};
         TC_CA:      sp = '{vtx(VX_C), vtx(VX_A)};
         TC_A_XBC:   sp = '{vtx(VX_A), xing(VX_B, VX_C)};
         TC_B_XCA:   sp = '{vtx(VX_B), xing(VX_C, VX_A)};
         TC_C_XAB:   sp = '{vtx(VX_C), xing(VX_A, VX_B)};
         TC_XAB_XBC: sp = '{xing(VX_A, VX_B), xing(VX_B, VX_C)};
         TC_XBC_XCA: sp = '{xing(VX_B, VX_C), xing(VX_C, VX_A)};
         TC_XCA_XAB: sp = '{xing(VX_C, VX_A), xing(VX_A, VX_B)};
         default:    sp = '{vtx(VX_A), vtx(VX_A)};
      endcase
      return sp;
   endfunction

   // Direct point or crossing; a flat edge falls back to its first end
   function automatic lane_type build_lane(logic is_cross,
                                           logic signed [H_BITS-1:0] h_p,
                                           logic signed [H_BITS-1:0] h_q,
                                           logic signed [COORD_BITS-1:0] c_p,
                                           logic signed [COORD_BITS-1:0] c_q);
      lane_type l;
      if (is_cross && (h_p != h_q)) begin
         l = '{hp: h_p, hq: h_q, cp: c_p, cq: c_q};
      end else begin
         l = '{hp: '0, hq: H_BITS'(1), cp: c_p, cq: '0};
      end
      return l;
   endfunction

   function automatic job_type empty_job();
      job_type j;
      j.has_segment = 1'b0;
      j.last = 1'b1;
      j.level_index = '0;
      for (int i = 0; i < LANES; i++) begin
         j.lane[i] = build_lane(1'b0, '0, '0, '0, '0);
      end
      return j;
   endfunction

endpackage

// ----- sv/ccs_channels.sv -----
interface ccs_req_if;
   import ccs_pkg::*;
   logic                          valid;
   logic                          ready;
   logic signed [CORNER_BITS-1:0] z_lower_left;
   logic signed [CORNER_BITS-1:0] z_lower_right;
   logic signed [CORNER_BITS-1:0] z_upper_right;
   logic signed [CORNER_BITS-1:0] z_upper_left;
   logic signed [CORNER_BITS-1:0] x_left;
   logic signed [CORNER_BITS-1:0] x_right;
   logic signed [CORNER_BITS-1:0] y_bottom;
   logic signed [CORNER_BITS-1:0] y_top;

   modport source (output valid, z_lower_left, z_lower_right, z_upper_right, z_upper_left,
                   x_left, x_right, y_bottom, y_top, input ready);
   modport sink (input valid, z_lower_left, z_lower_right, z_upper_right, z_upper_left,
                 x_left, x_right, y_bottom, y_top, output ready);
endinterface

interface ccs_rsp_if;
   import ccs_pkg::*;
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] start_x;
   logic signed [COORD_BITS-1:0] start_y;
   logic signed [COORD_BITS-1:0] end_x;
   logic signed [COORD_BITS-1:0] end_y;
   logic [LEVEL_IDX_BITS-1:0]    level_index;
   logic                         has_segment;
   logic                         last;

   modport source (output valid, start_x, start_y, end_x, end_y, level_index, has_segment,
                   last, input ready);
   modport sink (input valid, start_x, start_y, end_x, end_y, level_index, has_segment,
                 last, output ready);
endinterface

// ----- sv/ccs_fifo.sv -----
module ccs_fifo
   import ccs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type din,
   input  logic    pop,
   output job_type dout,
   output logic    full,
   output logic    empty
);

   localparam int PtrBits = $clog2(FIFO_DEPTH);

   job_type              mem_ff [FIFO_DEPTH];
   logic [PtrBits-1:0]   wr_ptr_ff;
   logic [PtrBits-1:0]   rd_ptr_ff;
   logic [PtrBits:0]     count_ff;

   assign full = (count_ff == (PtrBits+1)'(FIFO_DEPTH));
   assign empty = (count_ff == '0);
   assign dout = mem_ff[rd_ptr_ff];

   // Store entries
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= din;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop) rd_ptr_ff <= rd_ptr_ff + 1'b1;
         count_ff <= count_ff + (PtrBits+1)'(push) - (PtrBits+1)'(pop);
      end
   end

endmodule

// ----- sv/ccs_front.sv -----
module ccs_front
   import ccs_pkg::*;
#(
   parameter int MaxLevels = DEFAULT_MAX_LEVELS
)
(
   input  logic                      clock,
   input  logic                      reset,
   ccs_req_if.sink                   req_chan,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output job_type                   job_out,
   output logic                      job_push,
   input  logic                      job_full
);

   localparam int LvlIdxBits = (MaxLevels > 1) ? $clog2(MaxLevels) : 1;

   front_state_type state_ff, state_in;

   logic [LEVEL_IDX_BITS-1:0]     level_count_ff;
   logic signed [CORNER_BITS-1:0] level_ff [MaxLevels];

   logic signed [CORNER_BITS-1:0] z_ff [4];
   logic signed [CORNER_BITS-1:0] x_left_ff, x_right_ff, y_bottom_ff, y_top_ff;
   logic signed [CORNER_BITS-1:0] zmin_ff, zmax_ff;
   logic [LEVEL_IDX_BITS-1:0]     k_ff;
   logic [1:0]                    tri_ff;
   job_type                       pending_ff;
   logic                          pend_valid_ff;

   logic signed [CORNER_BITS-1:0] zmin_in, zmax_in, lv;
   logic [LEVEL_IDX_BITS-1:0]     cnt;
   logic [CSR_INDEX_BITS-1:0]     csr_slot;
   logic                          accept, at_end, in_range, found, advance, cell_done;
   logic signed [COORD_BITS-1:0]  d [4];
   logic signed [H_BITS-1:0]      h_corner [4];
   logic signed [H_BITS-1:0]      h_centre;
   logic signed [COORD_BITS-1:0]  cx_corner [4];
   logic signed [COORD_BITS-1:0]  cy_corner [4];
   logic signed [H_BITS-1:0]      vh [4];
   logic signed [COORD_BITS-1:0]  vx [4];
   logic signed [COORD_BITS-1:0]  vy [4];
   tri_case_type                  tc;
   seg_plan_type                  plan;
   job_type                       new_job;

   assign accept = req_chan.valid && req_chan.ready;
   assign csr_slot = csr_index - CSR_LEVEL_BASE;

   // Corner range of the incoming cell
   always_comb begin
      zmin_in = req_chan.z_lower_left;
      zmax_in = req_chan.z_lower_left;
      if (req_chan.z_lower_right < zmin_in) zmin_in = req_chan.z_lower_right;
      if (req_chan.z_lower_right > zmax_in) zmax_in = req_chan.z_lower_right;
      if (req_chan.z_upper_right < zmin_in) zmin_in = req_chan.z_upper_right;
      if (req_chan.z_upper_right > zmax_in) zmax_in = req_chan.z_upper_right;
      if (req_chan.z_upper_left < zmin_in) zmin_in = req_chan.z_upper_left;
      if (req_chan.z_upper_left > zmax_in) zmax_in = req_chan.z_upper_left;
   end

   // Classify the current level and triangle
   always_comb begin
      if (level_count_ff > LEVEL_IDX_BITS'(MaxLevels)) cnt = LEVEL_IDX_BITS'(MaxLevels);
      else cnt = level_count_ff;
      at_end = (k_ff >= cnt);
      lv = level_ff[k_ff[LvlIdxBits-1:0]];
      in_range = (lv >= zmin_ff) && (lv <= zmax_ff);
      for (int i = 0; i < 4; i++) begin
         d[i] = COORD_BITS'(z_ff[i]) - COORD_BITS'(lv);
         h_corner[i] = H_BITS'(d[i]) <<< 2;
      end
      h_centre = H_BITS'(d[0]) + H_BITS'(d[1]) + H_BITS'(d[2]) + H_BITS'(d[3]);
      cx_corner[0] = COORD_BITS'(x_left_ff) <<< 1;
      cx_corner[1] = COORD_BITS'(x_right_ff) <<< 1;
      cx_corner[2] = COORD_BITS'(x_right_ff) <<< 1;
      cx_corner[3] = COORD_BITS'(x_left_ff) <<< 1;
      cy_corner[0] = COORD_BITS'(y_bottom_ff) <<< 1;
      cy_corner[1] = COORD_BITS'(y_bottom_ff) <<< 1;
      cy_corner[2] = COORD_BITS'(y_top_ff) <<< 1;
      cy_corner[3] = COORD_BITS'(y_top_ff) <<< 1;

      vh[VX_A] = h_corner[tri_ff];
      vh[VX_B] = h_centre;
      vh[VX_C] = h_corner[tri_ff + 2'd1];
      vh[3] = '0;
      vx[VX_A] = cx_corner[tri_ff];
      vx[VX_B] = COORD_BITS'(x_left_ff) + COORD_BITS'(x_right_ff);
      vx[VX_C] = cx_corner[tri_ff + 2'd1];
      vx[3] = '0;
      vy[VX_A] = cy_corner[tri_ff];
      vy[VX_B] = COORD_BITS'(y_bottom_ff) + COORD_BITS'(y_top_ff);
      vy[VX_C] = cy_corner[tri_ff + 2'd1];
      vy[3] = '0;

      tc = tri_case_lookup(sign_code(vh[VX_A]), sign_code(vh[VX_B]), sign_code(vh[VX_C]));
      plan = case_points(tc);
      found = !at_end && in_range && (tc != TC_NONE);

      new_job.has_segment = 1'b1;
      new_job.last = 1'b0;
      new_job.level_index = k_ff;
      new_job.lane[0] = build_lane(plan.first.is_cross, vh[plan.first.p], vh[plan.first.q],
                                   vx[plan.first.p], vx[plan.first.q]);
      new_job.lane[1] = build_lane(plan.first.is_cross, vh[plan.first.p], vh[plan.first.q],
                                   vy[plan.first.p], vy[plan.first.q]);
      new_job.lane[2] = build_lane(plan.second.is_cross, vh[plan.second.p],
                                   vh[plan.second.q], vx[plan.second.p], vx[plan.second.q]);
      new_job.lane[3] = build_lane(plan.second.is_cross, vh[plan.second.p],
                                   vh[plan.second.q], vy[plan.second.p], vy[plan.second.q]);
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FR_IDLE: if (req_chan.valid) state_in = FR_SCAN;
         FR_SCAN: if (cell_done && !req_chan.valid) state_in = FR_IDLE;
         default: state_in = FR_IDLE;
      endcase
   end

   // Queue writes; hold one job back so the cell's final job carries last
   always_comb begin
      job_push = 1'b0;
      job_out = pending_ff;
      advance = 1'b0;
      cell_done = 1'b0;
      if (state_ff == FR_SCAN) begin
         priority if (at_end) begin
            if (pend_valid_ff) begin
               job_out.last = 1'b1;
            end else begin
               job_out = empty_job();
            end
            job_push = !job_full;
            cell_done = !job_full;
         end else if (found && pend_valid_ff) begin
            job_push = !job_full;
            advance = !job_full;
         end else begin
            advance = 1'b1;
         end
      end
      req_chan.ready = (state_ff == FR_IDLE) || cell_done;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FR_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= LEVEL_IDX_BITS'(1);
         for (int i = 0; i < MaxLevels; i++) level_ff[i] <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == CSR_LEVEL_COUNT) begin
            level_count_ff <= csr_wdata[LEVEL_IDX_BITS-1:0];
         end else if (int'(csr_slot) < MaxLevels) begin
            level_ff[csr_slot[LvlIdxBits-1:0]] <= csr_wdata;
         end
      end
   end

   // Walk levels and triangles of the held cell
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         k_ff <= '0;
         tri_ff <= '0;
      end else begin
         if (advance) begin
            if (!in_range) begin
               k_ff <= k_ff + 1'b1;
               tri_ff <= '0;
            end else begin
               tri_ff <= tri_ff + 2'd1;
               if (tri_ff == 2'd3) k_ff <= k_ff + 1'b1;
            end
            if (found) begin
               pend_valid_ff <= 1'b1;
            end
         end
         if (cell_done) pend_valid_ff <= 1'b0;
         if (accept) begin
            k_ff <= '0;
            tri_ff <= '0;
         end
      end
   end

   // Cell and pending job payload
   always_ff @(posedge clock) begin
      if (advance && found) pending_ff <= new_job;
      if (accept) begin
         z_ff[0] <= req_chan.z_lower_left;
         z_ff[1] <= req_chan.z_lower_right;
         z_ff[2] <= req_chan.z_upper_right;
         z_ff[3] <= req_chan.z_upper_left;
         x_left_ff <= req_chan.x_left;
         x_right_ff <= req_chan.x_right;
         y_bottom_ff <= req_chan.y_bottom;
         y_top_ff <= req_chan.y_top;
         zmin_ff <= zmin_in;
         zmax_ff <= zmax_in;
      end
   end

endmodule

// ----- sv/ccs_back.sv -----
module ccs_back
   import ccs_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  job_type job_in,
   input  logic    job_empty,
   output logic    job_pop,
   ccs_rsp_if.source rsp_chan
);

   back_state_type state_ff, state_in;

   logic                          has_ff, last_ff;
   logic [LEVEL_IDX_BITS-1:0]     level_ff;
   lane_type                      lane_ff [LANES];
   logic signed [PROD_BITS-1:0]   prod_a_ff [LANES];
   logic signed [PROD_BITS-1:0]   prod_b_ff [LANES];
   logic signed [DEN_BITS-1:0]    den_ff [LANES];
   logic [DEN_BITS-1:0]           dm_ff [LANES];
   logic                          neg_ff [LANES];
   logic [REM_BITS-1:0]           rem_ff [LANES];
   logic [QUO_BITS-1:0]           quo_ff [LANES];
   logic [DIV_STEP_BITS-1:0]      step_ff;

   logic                          out_valid_ff;
   logic signed [COORD_BITS-1:0]  out_coord_ff [LANES];
   logic                          out_has_ff, out_last_ff;
   logic [LEVEL_IDX_BITS-1:0]     out_level_ff;

   logic                          can_write, out_load;
   logic [REM_BITS-1:0]           rem_in [LANES];
   logic [QUO_BITS-1:0]           quo_in [LANES];
   logic signed [NUM_BITS-1:0]    num [LANES];
   logic [NUM_BITS-1:0]           nm [LANES];
   logic signed [COORD_BITS-1:0]  coord [LANES];

   assign can_write = !out_valid_ff || rsp_chan.ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         BK_IDLE: if (!job_empty) state_in = BK_MUL;
         BK_MUL:  state_in = BK_PREP;
         BK_PREP: state_in = BK_DIV;
         BK_DIV:  if (step_ff == DIV_STEP_BITS'(DIV_CYCLES - 1)) state_in = BK_DONE;
         BK_DONE: if (can_write) state_in = job_empty ? BK_IDLE : BK_MUL;
         default: state_in = BK_IDLE;
      endcase
   end

   // Outputs of the sequencer
   always_comb begin
      job_pop = 1'b0;
      out_load = 1'b0;
      unique case (state_ff)
         BK_IDLE: job_pop = !job_empty;
         BK_DONE: begin
            out_load = can_write;
            job_pop = can_write && !job_empty;
         end
         default: job_pop = 1'b0;
      endcase
   end

   // Divide datapath: numerator, magnitudes and three quotient bits a cycle
   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         num[l] = NUM_BITS'(prod_a_ff[l]) - NUM_BITS'(prod_b_ff[l]);
         nm[l] = num[l][NUM_BITS-1] ? NUM_BITS'(-num[l]) : NUM_BITS'(num[l]);
         rem_in[l] = rem_ff[l];
         quo_in[l] = quo_ff[l];
         for (int s = 0; s < DIV_BITS_PER_CYCLE; s++) begin
            rem_in[l] = {rem_in[l][REM_BITS-2:0], quo_in[l][QUO_BITS-1]};
            quo_in[l] = {quo_in[l][QUO_BITS-2:0], 1'b0};
            if (rem_in[l] >= {1'b0, dm_ff[l]}) begin
               rem_in[l] = rem_in[l] - {1'b0, dm_ff[l]};
               quo_in[l][0] = 1'b1;
            end
         end
         coord[l] = neg_ff[l] ? -COORD_BITS'(quo_ff[l]) : COORD_BITS'(quo_ff[l]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= BK_IDLE;
         step_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == BK_PREP) step_ff <= '0;
         else if (state_ff == BK_DIV) step_ff <= step_ff + 1'b1;
      end
   end

   // Job payload through the stages
   always_ff @(posedge clock) begin
      if (job_pop) begin
         has_ff <= job_in.has_segment;
         last_ff <= job_in.last;
         level_ff <= job_in.level_index;
         for (int l = 0; l < LANES; l++) lane_ff[l] <= job_in.lane[l];
      end
      for (int l = 0; l < LANES; l++) begin
         if (state_ff == BK_MUL) begin
            prod_a_ff[l] <= lane_ff[l].hq * lane_ff[l].cp;
            prod_b_ff[l] <= lane_ff[l].hp * lane_ff[l].cq;
            den_ff[l] <= DEN_BITS'(lane_ff[l].hq) - DEN_BITS'(lane_ff[l].hp);
         end
         if (state_ff == BK_PREP) begin
            neg_ff[l] <= num[l][NUM_BITS-1] ^ den_ff[l][DEN_BITS-1];
            dm_ff[l] <= den_ff[l][DEN_BITS-1] ? DEN_BITS'(-den_ff[l]) : DEN_BITS'(den_ff[l]);
            rem_ff[l] <= REM_BITS'(nm[l][NUM_BITS-1:QUO_BITS]);
            quo_ff[l] <= nm[l][QUO_BITS-1:0];
         end
         if (state_ff == BK_DIV) begin
            rem_ff[l] <= rem_in[l];
            quo_ff[l] <= quo_in[l];
         end
      end
   end

   // Output register parts the result from the next job
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         for (int l = 0; l < LANES; l++) out_coord_ff[l] <= coord[l];
         out_has_ff <= has_ff;
         out_last_ff <= last_ff;
         out_level_ff <= level_ff;
      end
   end

   assign rsp_chan.valid = out_valid_ff;
   assign rsp_chan.start_x = out_coord_ff[0];
   assign rsp_chan.start_y = out_coord_ff[1];
   assign rsp_chan.end_x = out_coord_ff[2];
   assign rsp_chan.end_y = out_coord_ff[3];
   assign rsp_chan.level_index = out_level_ff;
   assign rsp_chan.has_segment = out_has_ff;
   assign rsp_chan.last = out_last_ff;

endmodule

// ----- sv/contour_cell_segments.sv -----
// channel    dir  handshake        payload
// req_chan   in   valid/ready      four corner heights, x_left/x_right, y_bottom/y_top
// rsp_chan   out  valid/ready      segment end points (half units), level_index,
//                                  has_segment, last
// csr        in   csr_wr_en        csr_index selects level_count or level_a..level_f
//
// The front skips each level outside the corner range, walks the four triangles of each
// level inside it (one triangle a cycle while the job queue is not full) and then closes
// the cell; a new cell is taken in that closing cycle. Per result the back steps through
// multiply, prepare, the divide steps at three quotient bits each, and the write to the output register.
// A four-entry job queue lets the front run ahead of a stalled or busy back.
// Reset is synchronous: level_count returns to 1 and all levels to 0.
module contour_cell_segments
   import ccs_pkg::*;
#(
   parameter int MaxLevels = DEFAULT_MAX_LEVELS
)
(
   input  logic                      clock,
   input  logic                      reset,
   ccs_req_if.sink                   req_chan,
   ccs_rsp_if.source                 rsp_chan,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   job_type fifo_din, fifo_dout;
   logic    fifo_push, fifo_pop, fifo_full, fifo_empty;

   ccs_front #(.MaxLevels(MaxLevels)) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .job_out   (fifo_din),
      .job_push  (fifo_push),
      .job_full  (fifo_full)
   );

   ccs_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (fifo_push),
      .din   (fifo_din),
      .pop   (fifo_pop),
      .dout  (fifo_dout),
      .full  (fifo_full),
      .empty (fifo_empty)
   );

   ccs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_in    (fifo_dout),
      .job_empty (fifo_empty),
      .job_pop   (fifo_pop),
      .rsp_chan  (rsp_chan)
   );

   // Queue never written when full nor read when empty
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(fifo_push && fifo_full))
      else $error("job queue written while full");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(fifo_pop && fifo_empty))
      else $error("job queue read while empty");

   // The empty marker closes its cell and carries level zero
   a_empty_marker: assert property (@(posedge clock) disable iff (reset)
      (rsp_chan.valid && !rsp_chan.has_segment) |-> (rsp_chan.last && rsp_chan.level_index == '0))
      else $error("empty marker without last or with a level");

endmodule
